@@ rtl/dpp_pkg.sv @@
`timescale 1ns / 1ps

package dpp_pkg;

	localparam int DEPTH_W   = 16;
	localparam int PIX_W     = 11;
	localparam int COLOR_W   = 8;
	localparam int CENTER_W  = 16;
	localparam int INV_W     = 24;
	localparam int OFFSET_W  = 24;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 24;

	// Q12.4 pixel difference magnitude, product widths and output scaling
	localparam int DIFF_W     = CENTER_W + 1;
	localparam int ABS_W      = CENTER_W;
	localparam int PROD1_W    = ABS_W + DEPTH_W;
	localparam int PROD2_W    = PROD1_W + INV_W;
	localparam int FRAC_SHIFT = 28;
	localparam int QUOT_W     = PROD2_W - FRAC_SHIFT;

	localparam logic [CENTER_W-1:0] CENTER_X_RST = CENTER_W'(10240);
	localparam logic [CENTER_W-1:0] CENTER_Y_RST = CENTER_W'(5760);
	localparam logic [INV_W-1:0]    INV_FX_RST   = INV_W'(26214);
	localparam logic [INV_W-1:0]    INV_FY_RST   = INV_W'(26214);

	localparam logic signed [OFFSET_W-1:0] OFFSET_MAX = {1'b0, {(OFFSET_W-1){1'b1}}};
	localparam logic signed [OFFSET_W-1:0] OFFSET_MIN = {1'b1, {(OFFSET_W-1){1'b0}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CENTER_X    = 2'd0,
		CFG_CENTER_Y    = 2'd1,
		CFG_INV_FOCAL_X = 2'd2,
		CFG_INV_FOCAL_Y = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic [DEPTH_W-1:0] depth_raw;
		logic [PIX_W-1:0]   pixel_col;
		logic [PIX_W-1:0]   pixel_row;
		logic [COLOR_W-1:0] color_byte0;
		logic [COLOR_W-1:0] color_byte1;
		logic [COLOR_W-1:0] color_byte2;
	} pixel_t;

	typedef struct packed {
		logic [DEPTH_W-1:0]         dist_forward;
		logic signed [OFFSET_W-1:0] dist_left;
		logic signed [OFFSET_W-1:0] dist_up;
		logic [COLOR_W-1:0]         red;
		logic [COLOR_W-1:0]         green;
		logic [COLOR_W-1:0]         blue;
	} point_t;

	typedef struct packed {
		logic [CENTER_W-1:0] center_x;
		logic [CENTER_W-1:0] center_y;
		logic [INV_W-1:0]    inv_focal_x;
		logic [INV_W-1:0]    inv_focal_y;
	} cfg_t;

	// per-stage load enables, one per pipeline register rank
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

endpackage

@@ rtl/depth_pixel_to_point_core.sv @@
`timescale 1ns / 1ps
// Path: a pixel taken at a clock edge moves through the offset, depth product,
//   focal product and round/saturate registers to result, where result_valid
//   marks its point for one cycle.
// Throughput: one pixel per clock, sustained; busy stays low, nothing stalls the
//   four register stages (offset, depth product, focal product, round/saturate).
// Reset: arst_n clears the stage valid bits and loads the default intrinsics.

module depth_pixel_to_point_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  dpp_pkg::pixel_t               pixel,
	output logic                          result_valid,
	output dpp_pkg::point_t               result,
	input  logic                          cfg_we,
	input  dpp_pkg::cfg_index_t           cfg_index,
	input  logic [dpp_pkg::CFG_DAT_W-1:0] cfg_wdata
);

	dpp_pkg::cfg_t      cfg;
	dpp_pkg::stage_en_t en;
	logic               accept;
	logic               valid_s1;
	logic               valid_s2;
	logic               valid_s3;
	logic               valid_s4;

	logic [dpp_pkg::DEPTH_W-1:0] depth_s1, depth_s2, depth_s3, depth_s4;
	logic [3*dpp_pkg::COLOR_W-1:0] rgb_s1, rgb_s2, rgb_s3, rgb_s4;

	logic signed [dpp_pkg::OFFSET_W-1:0] left;
	logic signed [dpp_pkg::OFFSET_W-1:0] up;

	// The pipeline never stalls, so every start is taken at once.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	dpp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Valid bits: a zero depth drops the transaction right at the input.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= accept && (pixel.depth_raw != '0);
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Load each rank only when a live transaction moves into it.
	always_comb begin
		en.s1 = accept && (pixel.depth_raw != '0);
		en.s2 = valid_s1;
		en.s3 = valid_s2;
		en.s4 = valid_s3;
	end

	// Forward distance and color ride alongside the arithmetic; red is byte 2.
	always_ff @(posedge clk) begin
		if (en.s1) begin
			depth_s1 <= pixel.depth_raw;
			rgb_s1   <= {pixel.color_byte2, pixel.color_byte1, pixel.color_byte0};
		end
		if (en.s2) begin
			depth_s2 <= depth_s1;
			rgb_s2   <= rgb_s1;
		end
		if (en.s3) begin
			depth_s3 <= depth_s2;
			rgb_s3   <= rgb_s2;
		end
		if (en.s4) begin
			depth_s4 <= depth_s3;
			rgb_s4   <= rgb_s3;
		end
	end

	// Horizontal and vertical back-projection, one lane each.
	dpp_axis u_axis_x (
		.clk    (clk),
		.en     (en),
		.pix    (pixel.pixel_col),
		.depth  (pixel.depth_raw),
		.center (cfg.center_x),
		.inv    (cfg.inv_focal_x),
		.offset (left)
	);

	dpp_axis u_axis_y (
		.clk    (clk),
		.en     (en),
		.pix    (pixel.pixel_row),
		.depth  (pixel.depth_raw),
		.center (cfg.center_y),
		.inv    (cfg.inv_focal_y),
		.offset (up)
	);

	assign result_valid        = valid_s4;
	assign result.dist_forward = depth_s4;
	assign result.dist_left    = left;
	assign result.dist_up      = up;
	assign result.red          = rgb_s4[3*dpp_pkg::COLOR_W-1:2*dpp_pkg::COLOR_W];
	assign result.green        = rgb_s4[2*dpp_pkg::COLOR_W-1:dpp_pkg::COLOR_W];
	assign result.blue         = rgb_s4[dpp_pkg::COLOR_W-1:0];

`ifndef SYNTH
	a_valid_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(accept && (pixel.depth_raw != '0), 4))
		else $error("point emitted without a matching nonzero-depth transaction");

	a_accept_to_valid: assert property (@(posedge clk) disable iff (!arst_n)
		($past(accept && (pixel.depth_raw != '0), 4) && $past(arst_n, 1) &&
		 $past(arst_n, 2) && $past(arst_n, 3) && $past(arst_n, 4)) |-> result_valid)
		else $error("nonzero-depth transaction lost in the pipeline");

	a_forward_matches: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.dist_forward == $past(pixel.depth_raw, 4)))
		else $error("forward distance does not follow its transaction");

	a_red_matches: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.red == $past(pixel.color_byte2, 4)))
		else $error("color out of step with depth");
`endif

endmodule

@@ rtl/dpp_cfg_regs.sv @@
`timescale 1ns / 1ps

module dpp_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  dpp_pkg::cfg_index_t           cfg_index,
	input  logic [dpp_pkg::CFG_DAT_W-1:0] cfg_wdata,
	output dpp_pkg::cfg_t                 cfg
);

	dpp_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x    <= dpp_pkg::CENTER_X_RST;
			cfg_q.center_y    <= dpp_pkg::CENTER_Y_RST;
			cfg_q.inv_focal_x <= dpp_pkg::INV_FX_RST;
			cfg_q.inv_focal_y <= dpp_pkg::INV_FY_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				dpp_pkg::CFG_CENTER_X: begin
					cfg_q.center_x <= cfg_wdata[dpp_pkg::CENTER_W-1:0];
				end
				dpp_pkg::CFG_CENTER_Y: begin
					cfg_q.center_y <= cfg_wdata[dpp_pkg::CENTER_W-1:0];
				end
				dpp_pkg::CFG_INV_FOCAL_X: begin
					cfg_q.inv_focal_x <= cfg_wdata[dpp_pkg::INV_W-1:0];
				end
				dpp_pkg::CFG_INV_FOCAL_Y: begin
					cfg_q.inv_focal_y <= cfg_wdata[dpp_pkg::INV_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/dpp_axis.sv @@
`timescale 1ns / 1ps

module dpp_axis (
	input  logic                                 clk,
	input  dpp_pkg::stage_en_t                   en,
	input  logic [dpp_pkg::PIX_W-1:0]            pix,
	input  logic [dpp_pkg::DEPTH_W-1:0]          depth,
	input  logic [dpp_pkg::CENTER_W-1:0]         center,
	input  logic [dpp_pkg::INV_W-1:0]            inv,
	output logic signed [dpp_pkg::OFFSET_W-1:0]  offset
);

	logic [dpp_pkg::DIFF_W-1:0]   diff;
	logic [dpp_pkg::ABS_W-1:0]    diff_abs;
	logic [dpp_pkg::ABS_W-1:0]    abs_s1;
	logic                         neg_s1;
	logic [dpp_pkg::DEPTH_W-1:0]  depth_s1;
	logic [dpp_pkg::PROD1_W-1:0]  prod_s2;
	logic                         neg_s2;
	logic [dpp_pkg::PROD2_W-1:0]  prod_s3;
	logic                         neg_s3;
	logic [dpp_pkg::QUOT_W-1:0]   quot;
	logic                         frac_nz;
	logic [dpp_pkg::QUOT_W:0]     quot_up;
	logic signed [dpp_pkg::OFFSET_W-1:0] offset_d;
	logic signed [dpp_pkg::OFFSET_W-1:0] offset_s4;

	// pixel index to Q12.4, minus principal point; keep sign and magnitude
	assign diff = {2'b00, pix, 4'b0000} - {1'b0, center};
	assign diff_abs = diff[dpp_pkg::DIFF_W-1] ? dpp_pkg::ABS_W'(-diff)
	                                          : diff[dpp_pkg::ABS_W-1:0];

	always_ff @(posedge clk) begin
		if (en.s1) begin
			abs_s1   <= diff_abs;
			neg_s1   <= diff[dpp_pkg::DIFF_W-1];
			depth_s1 <= depth;
		end
		if (en.s2) begin
			prod_s2 <= abs_s1 * depth_s1;
			neg_s2  <= neg_s1;
		end
		if (en.s3) begin
			prod_s3 <= prod_s2 * inv;
			neg_s3  <= neg_s2;
		end
		if (en.s4) begin
			offset_s4 <= offset_d;
		end
	end

	// Floor of the signed product, negated: a negative difference gives
	// the ceiling of the magnitude, a positive one the negated floor.
	assign quot    = prod_s3[dpp_pkg::PROD2_W-1:dpp_pkg::FRAC_SHIFT];
	assign frac_nz = |prod_s3[dpp_pkg::FRAC_SHIFT-1:0];
	assign quot_up = {1'b0, quot} + {{dpp_pkg::QUOT_W{1'b0}}, frac_nz};

	always_comb begin
		if (neg_s3) begin
			if (quot_up > (dpp_pkg::QUOT_W+1)'(dpp_pkg::OFFSET_MAX))
				offset_d = dpp_pkg::OFFSET_MAX;
			else
				offset_d = quot_up[dpp_pkg::OFFSET_W-1:0];
		end else begin
			if (quot > dpp_pkg::QUOT_W'({1'b0, dpp_pkg::OFFSET_MIN}))
				offset_d = dpp_pkg::OFFSET_MIN;
			else
				offset_d = -quot[dpp_pkg::OFFSET_W-1:0];
		end
	end

	assign offset = offset_s4;

endmodule
